>>> rtl/lip_pkg.sv
// Shared types and constant tables for the Lehmer code permutation decoder.
`timescale 1ns / 1ps
package lip_pkg;

    // Fixed field widths
    localparam int INDEX_W = 16;
    localparam int ITEM_W  = 3;
    localparam int COUNT_W = 4;

    // Factorials 0! .. 7!, one per remaining digit count
    localparam logic [INDEX_W-1:0] FACT_TAB [8] = '{
        16'd1, 16'd1, 16'd2, 16'd6, 16'd24, 16'd120, 16'd720, 16'd5040
    };

    // Full range n! indexed by item count n (0 .. 8)
    localparam logic [INDEX_W-1:0] TOTAL_TAB [9] = '{
        16'd1, 16'd1, 16'd2, 16'd6, 16'd24, 16'd120, 16'd720, 16'd5040, 16'd40320
    };

    // Control broadcast along the pool cell row
    typedef struct packed {
        logic load;   // restore the identity pool
        logic shift;  // close the gap left by the taken entry
    } pool_ctrl_t;

    // Digit unit result
    typedef struct packed {
        logic [ITEM_W-1:0]  quotient;
        logic [INDEX_W-1:0] remainder;
    } digit_t;

endpackage

>>> rtl/lip_cell.sv
// One pool cell: holds one unused item and takes its right neighbor's on a shift.
`timescale 1ns / 1ps
module lip_cell (
    input  logic                       aclk,
    input  lip_pkg::pool_ctrl_t        ctrl,
    input  logic                       take,
    input  logic [lip_pkg::ITEM_W-1:0] init_item,
    input  logic [lip_pkg::ITEM_W-1:0] next_item,
    output logic [lip_pkg::ITEM_W-1:0] item
);
    import lip_pkg::*;

    logic [ITEM_W-1:0] item_reg;
    logic [ITEM_W-1:0] item_next;

    // Load identity, or pull the neighbor's item when at or past the gap
    always_comb begin
        item_next = item_reg;
        if (ctrl.load) begin
            item_next = init_item;
        end else if (ctrl.shift && take) begin
            item_next = next_item;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign item = item_reg;

endmodule

>>> rtl/lip_digit.sv
// Digit unit: one factoradic digit by comparing against multiples of a factorial.
`timescale 1ns / 1ps
module lip_digit (
    input  logic [lip_pkg::INDEX_W-1:0] rem_index,
    input  logic [lip_pkg::ITEM_W-1:0]  digit_count,
    input  logic [lip_pkg::COUNT_W-1:0] remaining,
    output lip_pkg::digit_t             digit
);
    import lip_pkg::*;

    logic [INDEX_W-1:0] fact;
    logic [INDEX_W-1:0] mult [8];
    logic [6:0]         ge;
    logic [ITEM_W-1:0]  q_raw;
    logic [ITEM_W-1:0]  q_max;

    assign fact = FACT_TAB[digit_count];

    // Constant multiples of the selected factorial
    genvar k;
    generate
        for (k = 0; k < 8; k++) begin : g_mult
            assign mult[k] = INDEX_W'(fact * INDEX_W'(k));
        end
        for (k = 1; k < 8; k++) begin : g_cmp
            assign ge[k-1] = (rem_index >= mult[k]);
        end
    endgenerate

    // Quotient is the number of nonzero multiples not above the index
    always_comb begin
        q_raw = '0;
        for (int i = 0; i < 7; i++) begin
            q_raw = q_raw + ITEM_W'(ge[i]);
        end
    end

    // Clamp the pick to the last pool entry still in use
    assign q_max = ITEM_W'(remaining - COUNT_W'(1));

    always_comb begin
        digit.remainder = rem_index - mult[q_raw];
        digit.quotient  = (q_raw > q_max) ? q_max : q_raw;
    end

endmodule

>>> rtl/lehmer_index_to_permutation.sv
// Top level: Lehmer code decoder from permutation index to a stream of item picks.
//
//   channel   ports                                       direction
//   input     s_valid s_ready s_perm_index                in
//   result    m_valid m_ready m_position m_original_item  out
//             m_last m_index_error
//   config    cfg_valid cfg_ready cfg_data (item_count)   in
//
// Accepting an index loads the pool cell row; each step then yields the result for
// one position, set by the digit unit feeding the pool cells. An index of N! or
// more yields one error result. No new index is accepted while busy.
// Reset (aresetn low, synchronous) clears control and sets item_count to 8.
// A stall on m_ready holds the digit sequence; the result register holds.
`timescale 1ns / 1ps
module lehmer_index_to_permutation #(
    parameter int MAX_ITEMS = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [lip_pkg::INDEX_W-1:0] s_perm_index,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lip_pkg::ITEM_W-1:0]  m_position,
    output logic [lip_pkg::ITEM_W-1:0]  m_original_item,
    output logic                        m_last,
    output logic                        m_index_error,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lip_pkg::COUNT_W-1:0] cfg_data
);
    import lip_pkg::*;

    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    // Configuration
    logic [COUNT_W-1:0] item_count_reg;
    logic [COUNT_W-1:0] n_eff;

    // Control and working state
    logic               busy_reg;
    logic               err_reg;
    logic [ITEM_W-1:0]  pos_reg;
    logic [COUNT_W-1:0] n_reg;
    logic [INDEX_W-1:0] rem_reg;

    // Result register
    logic               m_valid_reg;
    logic [ITEM_W-1:0]  m_position_reg;
    logic [ITEM_W-1:0]  m_item_reg;
    logic               m_last_reg;
    logic               m_err_reg;

    logic               accept;
    logic               step;
    logic [COUNT_W-1:0] remaining;
    logic [ITEM_W-1:0]  digit_count;
    logic               last_pos;
    digit_t             digit;
    pool_ctrl_t         pool_ctrl;
    logic [ITEM_W-1:0]  pool_item [MAX_ITEMS];
    logic [ITEM_W-1:0]  pick;

    // Accept the configuration write at any time; register it
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_count_reg <= COUNT_W'(8);
        end else if (cfg_valid && cfg_ready) begin
            item_count_reg <= cfg_data;
        end
    end

    // Clamp the item count into 1 .. MAX_ITEMS
    always_comb begin
        n_eff = item_count_reg;
        if (n_eff == '0) begin
            n_eff = COUNT_W'(1);
        end
        if (n_eff > COUNT_W'(MAX_ITEMS)) begin
            n_eff = COUNT_W'(MAX_ITEMS);
        end
    end

    // Handshake
    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;
    assign step    = busy_reg && (!m_valid_reg || m_ready);

    assign remaining   = n_reg - COUNT_W'(pos_reg);
    assign digit_count = ITEM_W'(remaining - COUNT_W'(1));
    assign last_pos    = (remaining == COUNT_W'(1));

    lip_digit u_digit (
        .rem_index   (rem_reg),
        .digit_count (digit_count),
        .remaining   (remaining),
        .digit       (digit)
    );

    // Pool cell row
    assign pool_ctrl.load  = accept;
    assign pool_ctrl.shift = step && !err_reg;

    genvar i;
    generate
        for (i = 0; i < MAX_ITEMS; i++) begin : g_pool
            logic [ITEM_W-1:0] next_item;
            if (i == MAX_ITEMS - 1) begin : g_end
                assign next_item = pool_item[i];
            end else begin : g_mid
                assign next_item = pool_item[i+1];
            end
            lip_cell u_cell (
                .aclk      (aclk),
                .ctrl      (pool_ctrl),
                .take      (digit.quotient <= ITEM_W'(i)),
                .init_item (ITEM_W'(i)),
                .next_item (next_item),
                .item      (pool_item[i])
            );
        end
    endgenerate

    assign pick = pool_item[digit.quotient[IDX_W-1:0]];

    // Sequence control: load on accept, advance one position per step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (accept) begin
            busy_reg <= 1'b1;
        end else if (step && (err_reg || last_pos)) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            n_reg   <= n_eff;
            err_reg <= (s_perm_index >= TOTAL_TAB[n_eff]);
            rem_reg <= s_perm_index;
            pos_reg <= '0;
        end else if (step) begin
            rem_reg <= digit.remainder;
            pos_reg <= pos_reg + ITEM_W'(1);
        end
    end

    // Result register: fill on step, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            if (err_reg) begin
                m_position_reg <= '0;
                m_item_reg     <= '0;
                m_last_reg     <= 1'b1;
                m_err_reg      <= 1'b1;
            end else begin
                m_position_reg <= pos_reg;
                m_item_reg     <= pick;
                m_last_reg     <= last_pos;
                m_err_reg      <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_position      = m_position_reg;
    assign m_original_item = m_item_reg;
    assign m_last          = m_last_reg;
    assign m_index_error   = m_err_reg;

endmodule

>>> test/lip_pick_checker.sv
// Checker for the permutation decoder: tracks item_count, predicts picks, compares results.
`timescale 1ns / 1ps
module lip_pick_checker #(
    parameter int MAX_ITEMS = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [lip_pkg::INDEX_W-1:0] s_perm_index,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [lip_pkg::ITEM_W-1:0]  m_position,
    input  logic [lip_pkg::ITEM_W-1:0]  m_original_item,
    input  logic                        m_last,
    input  logic                        m_index_error,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [lip_pkg::COUNT_W-1:0] cfg_data,
    output int                          failures,
    output int                          outstanding
);

    typedef struct packed {
        logic [lip_pkg::ITEM_W-1:0] position;
        logic [lip_pkg::ITEM_W-1:0] original_item;
        logic                       last;
        logic                       index_error;
    } pick_t;

    pick_t                       expected_picks [$];
    logic [lip_pkg::COUNT_W-1:0] count_reg  = 4'd8;
    int                          fail_count = 0;

    function automatic int factorial(input int k);
        int acc;
        acc = 1;
        for (int i = 2; i <= k; i++) acc = acc * i;
        return acc;
    endfunction

    // Expand one permutation index into its expected picks
    function automatic void decode_perm(input logic [lip_pkg::INDEX_W-1:0] idx);
        int                         n;
        int                         rem;
        int                         f;
        int                         q;
        int                         left;
        logic [lip_pkg::ITEM_W-1:0] pool [8];
        pick_t                      p;
        n = int'(count_reg);
        if (n < 1) n = 1;
        if (n > MAX_ITEMS) n = MAX_ITEMS;
        // Out-of-range index gives a single error pick
        if (int'(idx) >= factorial(n)) begin
            p.position      = '0;
            p.original_item = '0;
            p.last          = 1'b1;
            p.index_error   = 1'b1;
            expected_picks.push_back(p);
            return;
        end
        for (int i = 0; i < 8; i++) pool[i] = i[lip_pkg::ITEM_W-1:0];
        rem  = int'(idx);
        left = n;
        for (int pos = 0; pos < n; pos++) begin
            f   = factorial(n - 1 - pos);
            q   = rem / f;
            rem = rem % f;
            if (q >= left) q = left - 1;
            p.position      = pos[lip_pkg::ITEM_W-1:0];
            p.original_item = pool[q];
            p.last          = (pos + 1 == n);
            p.index_error   = 1'b0;
            expected_picks.push_back(p);
            // Close the gap left by the taken entry
            for (int k = q; k + 1 < left; k++) pool[k] = pool[k+1];
            left--;
        end
    endfunction

    // Compare one accepted result against the oldest expected pick
    task automatic check_pick();
        pick_t exp_pick;
        if (expected_picks.size() == 0) begin
            $error("unexpected result: position %0d, original_item %0d",
                   m_position, m_original_item);
            fail_count++;
        end else begin
            exp_pick = expected_picks.pop_front();
            if (m_position !== exp_pick.position) begin
                $error("position: expected %0d, actual %0d", exp_pick.position, m_position);
                fail_count++;
            end
            if (m_original_item !== exp_pick.original_item) begin
                $error("original_item: expected %0d, actual %0d",
                       exp_pick.original_item, m_original_item);
                fail_count++;
            end
            if (m_last !== exp_pick.last) begin
                $error("last: expected %0d, actual %0d", exp_pick.last, m_last);
                fail_count++;
            end
            if (m_index_error !== exp_pick.index_error) begin
                $error("index_error: expected %0d, actual %0d",
                       exp_pick.index_error, m_index_error);
                fail_count++;
            end
        end
    endtask

    // Watch every channel at the clock edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            count_reg = 4'd8;
            expected_picks.delete();
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) count_reg = cfg_data;
            if (m_valid && m_ready) check_pick();
            if (s_valid && s_ready) decode_perm(s_perm_index);
            outstanding <= expected_picks.size();
        end
        failures <= fail_count;
    end

endmodule

>>> test/tb.sv
// Testbench top for the permutation decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;

    localparam int MAX_ITEMS  = 8;
    localparam int LIMIT      = 400000;
    localparam int HOLD_LEN   = 400;
    localparam int NUM_PHASES = 12;
    localparam int PHASE_LEN  = 34;

    logic                        aclk         = 1'b0;
    logic                        aresetn      = 1'b0;
    logic                        s_valid      = 1'b0;
    logic                        s_ready;
    logic [lip_pkg::INDEX_W-1:0] s_perm_index = '0;
    logic                        m_valid;
    logic                        m_ready      = 1'b0;
    logic [lip_pkg::ITEM_W-1:0]  m_position;
    logic [lip_pkg::ITEM_W-1:0]  m_original_item;
    logic                        m_last;
    logic                        m_index_error;
    logic                        cfg_valid    = 1'b0;
    logic                        cfg_ready;
    logic [lip_pkg::COUNT_W-1:0] cfg_data     = 4'd8;

    int failures;
    int outstanding;
    int cycle_count  = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_req     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int cur_count    = 8;

    int phase_counts [NUM_PHASES] = '{8, 1, 4, 7, 8, 2, 0, 6, 15, 3, 5, 8};

    lehmer_index_to_permutation #(.MAX_ITEMS(MAX_ITEMS)) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_perm_index    (s_perm_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_position      (m_position),
        .m_original_item (m_original_item),
        .m_last          (m_last),
        .m_index_error   (m_index_error),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    lip_pick_checker #(.MAX_ITEMS(MAX_ITEMS)) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_perm_index    (s_perm_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_position      (m_position),
        .m_original_item (m_original_item),
        .m_last          (m_last),
        .m_index_error   (m_index_error),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .failures        (failures),
        .outstanding     (outstanding)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Drive m_ready: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            m_ready   <= 1'b0;
            hold_seen <= hold_req;
            hold_left <= HOLD_LEN;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic int total_of(input int cnt);
        int n;
        int acc;
        n = (cnt < 1) ? 1 : ((cnt > MAX_ITEMS) ? MAX_ITEMS : cnt);
        acc = 1;
        for (int i = 2; i <= n; i++) acc = acc * i;
        return acc;
    endfunction

    // Mostly in-range indices, some at the boundary, some anywhere
    function automatic logic [lip_pkg::INDEX_W-1:0] random_index(input int cnt);
        int total;
        int r;
        int v;
        total = total_of(cnt);
        r     = $urandom_range(99);
        if (r < 70) begin
            v = $urandom_range(total - 1, 0);
        end else if (r < 75) begin
            v = total - 1;
        end else if (r < 80) begin
            v = total;
        end else begin
            v = $urandom_range(65535, 0);
        end
        return v[lip_pkg::INDEX_W-1:0];
    endfunction

    // Offer one transaction and hold it until accepted
    task automatic send_index(input logic [lip_pkg::INDEX_W-1:0] idx);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_perm_index <= idx;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Wait until every expected pick has arrived
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Write item_count once the block is idle
    task automatic write_count(input logic [lip_pkg::COUNT_W-1:0] value);
        drain();
        repeat (12) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        cur_count = int'(value);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, boundaries and count clamping
        tx_idle_pct = 35;
        rx_stall_pct <= 35;
        send_index(16'd0);
        send_index(16'd1);
        send_index(16'd40319);
        send_index(16'd40320);
        send_index(16'hFFFF);
        send_index(16'h5555);
        send_index(16'hAAAA);
        write_count(4'd1);
        send_index(16'd0);
        send_index(16'd1);
        send_index(16'hFFFF);
        write_count(4'd0);
        send_index(16'd0);
        send_index(16'd1);
        write_count(4'd15);
        send_index(16'd40319);
        send_index(16'd40320);
        write_count(4'd9);
        send_index(16'd12345);
        write_count(4'd2);
        send_index(16'd0);
        send_index(16'd1);
        send_index(16'd2);
        write_count(4'd3);
        send_index(16'd5);
        send_index(16'd6);
        write_count(4'd5);
        send_index(16'd119);
        send_index(16'd120);
        write_count(4'd7);
        send_index(16'd5039);
        send_index(16'd5040);

        // Random phases over counts and idle patterns
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_count(phase_counts[ph][lip_pkg::COUNT_W-1:0]);
            case (ph % 4)
                0: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 0;
                end
                1: begin
                    tx_idle_pct = 73;
                    rx_stall_pct <= 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 73;
                end
                default: begin
                    tx_idle_pct = 35;
                    rx_stall_pct <= 35;
                end
            endcase
            // Back up the block while the sender keeps pushing
            if (ph == 4) hold_req <= hold_req + 1;
            for (int i = 0; i < PHASE_LEN; i++) begin
                if (i == PHASE_LEN / 2) drain();
                send_index(random_index(cur_count));
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        if (failures == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
